// ===== design/fdp_pkg.sv =====
// Shared types and constants for the frame decimating packetizer.
// Holds frame geometry, packet sizing, register indexes and the queue record.
// No dependencies.
package fdp_pkg;

  localparam int FRAME_WIDTH      = 640;
  localparam int FRAME_HEIGHT     = 480;
  localparam int BYTES_PER_PIXEL  = 4;
  localparam int MAX_PACKET_BYTES = 1024;

  localparam int HEADER_BYTES  = 8;
  localparam int PAYLOAD_BYTES = MAX_PACKET_BYTES - HEADER_BYTES;

  localparam int COL_W  = $clog2(FRAME_WIDTH);
  localparam int ROW_W  = $clog2(FRAME_HEIGHT);
  localparam int BYTE_W = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1;

  localparam int KEEP_WIDTH  = (FRAME_WIDTH / 2) * 2;
  localparam int KEEP_HEIGHT = (FRAME_HEIGHT / 2) * 2;

  localparam int TOTAL_FULL = FRAME_WIDTH * FRAME_HEIGHT * BYTES_PER_PIXEL;
  localparam int TOTAL_LOW  = (FRAME_WIDTH / 2) * (FRAME_HEIGHT / 2) * BYTES_PER_PIXEL;
  localparam int TOTAL_W    = $clog2(TOTAL_FULL + 1);
  localparam int FILL_W     = $clog2(PAYLOAD_BYTES + 1);

  localparam int CHUNKS_FULL = (TOTAL_FULL + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;
  localparam int CHUNKS_LOW  = (TOTAL_LOW + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;

  localparam int PHASE_W = $clog2(HEADER_BYTES + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic CFG_ENABLE  = 1'b0;
  localparam logic CFG_LOW_RES = 1'b1;

  typedef struct packed {
    logic [15:0] chunk_count;
    logic [15:0] packet_index;
    logic [31:0] frame_number;
    logic        header;
    logic        end_of_packet;
    logic        end_of_frame;
    logic [7:0]  pixel_byte;
  } fdp_item_t;

endpackage

// ===== design/fdp_front.sv =====
// Front part of the packetizer: configuration, raster position, decimation and packet bookkeeping.
// Classifies each accepted byte and pushes a record for kept bytes.
// Depends on fdp_pkg.
module fdp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic              cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  output logic              push_valid,
  input  logic              push_ready,
  output fdp_pkg::fdp_item_t push_item
);

  logic                        enable_r;
  logic                        low_res_r;
  logic [fdp_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [fdp_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [fdp_pkg::BYTE_W-1:0]  bop_r, bop_nxt;
  logic [fdp_pkg::FILL_W-1:0]  fill_r, fill_inc;
  logic [15:0]                 pidx_r;
  logic [fdp_pkg::TOTAL_W-1:0] sent_r, sent_inc, total;
  logic [31:0]                 frame_r;
  logic [15:0]                 chunks;
  logic                        kept, accept, push, eof, eop;

  always_comb begin
    kept = !low_res_r ||
           (!col_r[0] && !row_r[0] &&
            ({1'b0, col_r} < (fdp_pkg::COL_W+1)'(fdp_pkg::KEEP_WIDTH)) &&
            ({1'b0, row_r} < (fdp_pkg::ROW_W+1)'(fdp_pkg::KEEP_HEIGHT)));
    total  = low_res_r ? fdp_pkg::TOTAL_W'(fdp_pkg::TOTAL_LOW)
                       : fdp_pkg::TOTAL_W'(fdp_pkg::TOTAL_FULL);
    chunks = low_res_r ? 16'(fdp_pkg::CHUNKS_LOW) : 16'(fdp_pkg::CHUNKS_FULL);
    sent_inc = sent_r + 1'b1;
    fill_inc = fill_r + 1'b1;
    eof = sent_inc >= total;
    eop = eof || (fill_inc >= fdp_pkg::FILL_W'(fdp_pkg::PAYLOAD_BYTES));

    in_tready  = !enable_r || !kept || push_ready;
    accept     = in_tvalid && in_tready && enable_r;
    push       = accept && kept;
    push_valid = enable_r && kept && in_tvalid;

    push_item.chunk_count   = chunks;
    push_item.packet_index  = pidx_r;
    push_item.frame_number  = frame_r;
    push_item.header        = (fill_r == '0);
    push_item.end_of_packet = eop;
    push_item.end_of_frame  = eof;
    push_item.pixel_byte    = in_tdata;

    bop_nxt = bop_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (bop_r == fdp_pkg::BYTE_W'(fdp_pkg::BYTES_PER_PIXEL - 1)) begin
      bop_nxt = '0;
      if (col_r == fdp_pkg::COL_W'(fdp_pkg::FRAME_WIDTH - 1)) begin
        col_nxt = '0;
        if (row_r == fdp_pkg::ROW_W'(fdp_pkg::FRAME_HEIGHT - 1)) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end else begin
      bop_nxt = bop_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      low_res_r <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
      bop_r     <= '0;
      fill_r    <= '0;
      pidx_r    <= '0;
      sent_r    <= '0;
      frame_r   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == fdp_pkg::CFG_ENABLE) begin
        enable_r <= cfg_wdata;
        if (cfg_wdata) begin
          col_r   <= '0;
          row_r   <= '0;
          bop_r   <= '0;
          fill_r  <= '0;
          pidx_r  <= '0;
          sent_r  <= '0;
          frame_r <= '0;
        end
      end else begin
        low_res_r <= cfg_wdata;
      end
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      bop_r <= bop_nxt;
      if (push) begin
        if (eof) begin
          sent_r  <= '0;
          fill_r  <= '0;
          pidx_r  <= '0;
          frame_r <= frame_r + 1'b1;
        end else begin
          sent_r <= sent_inc;
          if (eop) begin
            fill_r <= '0;
            pidx_r <= pidx_r + 1'b1;
          end else begin
            fill_r <= fill_inc;
          end
        end
      end
    end
  end

endmodule

// ===== design/fdp_queue.sv =====
// Short queue of classified byte records between the front and back parts.
// Register-based, one push and one pop per cycle; a push only while not full, a pop only while not empty.
// Depends on fdp_pkg.
module fdp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  fdp_pkg::fdp_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output fdp_pkg::fdp_item_t pop_item
);

  fdp_pkg::fdp_item_t               mem_r [fdp_pkg::QUEUE_DEPTH];
  logic [fdp_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [fdp_pkg::QPTR_W:0]         count_r;
  logic                             do_push, do_pop;

  always_comb begin
    push_ready = (count_r != (fdp_pkg::QPTR_W+1)'(fdp_pkg::QUEUE_DEPTH));
    pop_valid  = (count_r != '0);
    pop_item   = mem_r[rd_ptr_r];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/fdp_back.sv =====
// Back part of the packetizer: expands each record into header and payload bytes.
// Holds the record being sent and the output register of the result stream.
// Depends on fdp_pkg.
module fdp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  fdp_pkg::fdp_item_t pop_item,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast,
  output logic               out_tuser
);

  fdp_pkg::fdp_item_t            cur_r;
  logic                          cur_valid_r;
  logic [fdp_pkg::PHASE_W-1:0]   phase_r;
  logic                          out_valid_r;
  logic [7:0]                    out_byte_r, byte_nxt;
  logic                          out_eop_r, out_eof_r, eop_nxt, eof_nxt;
  logic [63:0]                   hdr_vec;
  logic                          out_load, last_of_rec, consume, in_header;

  always_comb begin
    hdr_vec     = {cur_r.chunk_count, cur_r.packet_index, cur_r.frame_number};
    in_header   = cur_r.header && (phase_r != fdp_pkg::PHASE_W'(fdp_pkg::HEADER_BYTES));
    last_of_rec = !in_header;
    out_load    = cur_valid_r && (!out_valid_r || out_tready);
    consume     = out_load && last_of_rec;
    pop_ready   = !cur_valid_r || consume;
    if (in_header) begin
      byte_nxt = hdr_vec[{phase_r[2:0], 3'b000} +: 8];
      eop_nxt  = 1'b0;
      eof_nxt  = 1'b0;
    end else begin
      byte_nxt = cur_r.pixel_byte;
      eop_nxt  = cur_r.end_of_packet;
      eof_nxt  = cur_r.end_of_frame;
    end
    out_tvalid = out_valid_r;
    out_tdata  = out_byte_r;
    out_tlast  = out_eop_r;
    out_tuser  = out_eof_r;
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur_r <= pop_item;
    end
    if (out_load) begin
      out_byte_r <= byte_nxt;
      out_eop_r  <= eop_nxt;
      out_eof_r  <= eof_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop_ready) begin
        cur_valid_r <= pop_valid;
      end
      if (out_load) begin
        phase_r <= last_of_rec ? '0 : phase_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== design/frame_decimating_packetizer.sv =====
// Top level of the frame decimating packetizer.
// Connects the classifying front, the record queue and the packet-building back.
// Depends on fdp_pkg, fdp_front, fdp_queue and fdp_back.
//
//   Channel  Direction  Payload
//   in_      input      tdata[7:0] pixel byte
//   out_     output     tdata[7:0] packet byte, tlast end of packet, tuser end of frame
//   cfg_     input      index 0 enable, index 1 low resolution
//
// One input byte can be taken every cycle. A kept byte that opens a packet produces nine
// output bytes, any other kept byte one; the four-entry record queue absorbs the header
// bursts and the input stalls only when it is full. Dropped and discarded bytes are taken
// without stalling. Reset clears all control state; no clearing pass is needed.
module frame_decimating_packetizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] pixel_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic       out_tuser   // [0] end_of_frame
);

  logic               push_valid, push_ready, pop_valid, pop_ready;
  fdp_pkg::fdp_item_t push_item, pop_item;

  fdp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  fdp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  fdp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
